// ----- src/motor_feedback_tracker_macros.svh -----
// Assertion macros for the motor feedback tracker.
`ifndef MOTOR_FEEDBACK_TRACKER_MACROS_SVH
`define MOTOR_FEEDBACK_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/mft_pkg.sv -----
// Shared types and constants of the motor feedback tracker.
package mft_pkg;
    localparam int unsigned SlotW = 3;
    localparam int unsigned DivSteps = 42;

    localparam logic [2:0] RegPulses = 3'd0;
    localparam logic [2:0] RegCounts = 3'd1;
    localparam logic [2:0] RegBegin = 3'd2;
    localparam logic [2:0] RegEnable = 3'd3;
    localparam logic [2:0] RegStuck = 3'd4;

    localparam logic OpFrame = 1'b0;
    localparam logic OpTick = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_UPDATE, ST_MULT, ST_DIV, ST_OUT
    } t_state;

    // controller commands to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic mult;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath status to controller
    typedef struct packed {
        logic div_done;
    } t_status;
endpackage

// ----- src/mft_ctrl.sv -----
// Sequencer of the motor feedback tracker.
module mft_ctrl
    import mft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands; result register frees as soon as it is taken
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        n_out_valid = r_out_valid && i_stall;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!n_out_valid) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_out_valid;
endmodule

// ----- src/mft_dp.sv -----
// Per-motor state table, frame/tick update and degree divider.
module mft_dp
    import mft_pkg::*;
#(
    parameter int unsigned MOTORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_operation,
    input  logic [2:0]         i_motor_index,
    input  logic [12:0]        i_angle_raw,
    input  logic signed [15:0] i_speed_raw,
    input  logic signed [15:0] i_current_raw,
    input  logic [7:0]         i_temperature_raw,
    output logic [2:0]         o_slot,
    output logic signed [31:0] o_total_count,
    output logic signed [31:0] o_angle_degrees,
    output logic signed [13:0] o_step_count,
    output logic signed [31:0] o_lock_count,
    output logic signed [15:0] o_speed_now,
    output logic signed [15:0] o_current_now,
    output logic [7:0]         o_temperature_now,
    output logic               o_drive_enabled,
    output logic               o_stall_alarm
);
    localparam int unsigned IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // configuration
    logic [15:0] r_ppr;
    logic [23:0] r_cpt;
    logic [7:0]  r_begin, r_enable;
    logic        r_stuck;

    // per-motor state
    logic [12:0]        r_prev [MOTORS];
    logic signed [31:0] r_total [MOTORS];
    logic signed [31:0] r_held [MOTORS];
    logic signed [13:0] r_lstep [MOTORS];
    logic signed [15:0] r_speed [MOTORS];
    logic signed [15:0] r_cur [MOTORS];
    logic [7:0]         r_temp [MOTORS];
    logic [MOTORS-1:0]  r_zero, r_fault, r_alarm;
    logic [9:0]         r_stallc [MOTORS];
    logic [4:0]         r_age [MOTORS];
    logic [3:0]         r_tmo [MOTORS];

    // latched request
    logic               r_op, r_oob;
    logic [2:0]         r_slot;
    logic [12:0]        r_ang;
    logic signed [15:0] r_spd, r_curin;
    logic [7:0]         r_tin;

    logic [IdxW-1:0] w_m;
    assign w_m = r_slot[IdxW-1:0];

    // config writes, enable write clears faults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= 16'd8191;
            r_cpt <= 24'd155629;
            r_begin <= '0;
            r_enable <= '0;
            r_stuck <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegPulses: r_ppr <= i_cfg_data[15:0];
                RegCounts: r_cpt <= i_cfg_data;
                RegBegin: r_begin <= i_cfg_data[7:0];
                RegEnable: r_enable <= i_cfg_data[7:0];
                RegStuck: r_stuck <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_slot <= i_motor_index;
            r_oob <= ({29'd0, i_motor_index} >= MOTORS);
            r_ang <= i_angle_raw;
            r_spd <= i_speed_raw;
            r_curin <= i_current_raw;
            r_tin <= i_temperature_raw;
        end
    end

    // frame step arithmetic
    logic signed [17:0] w_diff, w_step;
    logic signed [31:0] w_sum;
    logic signed [13:0] w_sat;
    always_comb begin
        w_diff = $signed({5'd0, r_ang}) - $signed({5'd0, r_prev[w_m]});
        if (w_diff > 18'sd4096) w_step = w_diff - $signed({2'd0, r_ppr});
        else if (w_diff < -18'sd4096) w_step = w_diff + $signed({2'd0, r_ppr});
        else w_step = w_diff;
        w_sum = r_total[w_m] + 32'(w_step);
        if (w_step > 18'sd8191) w_sat = 14'sd8191;
        else if (w_step < -18'sd8192) w_sat = -14'sd8192;
        else w_sat = w_step[13:0];
    end

    logic w_run;
    assign w_run = r_begin[w_m] && r_enable[w_m] && !r_fault[w_m];

    // state table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTORS; i++) begin
                r_prev[i] <= '0; r_total[i] <= '0; r_held[i] <= '0;
                r_lstep[i] <= '0; r_speed[i] <= '0; r_cur[i] <= '0;
                r_temp[i] <= '0; r_stallc[i] <= '0; r_age[i] <= '0;
                r_tmo[i] <= '0;
            end
            r_zero <= '1; r_fault <= '0; r_alarm <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index == RegEnable) begin
                r_fault <= r_fault & ~i_cfg_data[MOTORS-1:0];
            end
            if (i_cmd.update && !r_oob) begin
                if (r_op == OpFrame) begin
                    r_prev[w_m] <= r_ang;
                    r_lstep[w_m] <= w_sat;
                    r_speed[w_m] <= r_spd;
                    r_cur[w_m] <= r_curin;
                    r_temp[w_m] <= r_tin;
                    r_age[w_m] <= '0;
                    if (r_zero[w_m]) begin
                        r_total[w_m] <= '0;
                        r_held[w_m] <= '0;
                        r_zero[w_m] <= 1'b0;
                    end else begin
                        r_total[w_m] <= w_sum;
                        if (r_begin[w_m]) r_held[w_m] <= w_sum;
                    end
                end else if (w_run) begin
                    if (r_lstep[w_m] < 14'sd5 && r_cur[w_m] > 16'sd3000) begin
                        if (r_stallc[w_m] > 10'd500) begin
                            r_stallc[w_m] <= '0;
                            r_alarm[w_m] <= 1'b1;
                            if (r_stuck) r_fault[w_m] <= 1'b1;
                        end else begin
                            r_stallc[w_m] <= r_stallc[w_m] + 10'd1;
                        end
                    end else begin
                        r_stallc[w_m] <= '0;
                    end
                    if (r_age[w_m] < 5'd31) r_age[w_m] <= r_age[w_m] + 5'd1;
                    if (r_age[w_m] > 5'd20) begin
                        if (r_tmo[w_m] > 4'd10) begin
                            r_tmo[w_m] <= '0;
                            r_fault[w_m] <= 1'b1;
                        end else begin
                            r_tmo[w_m] <= r_tmo[w_m] + 4'd1;
                        end
                    end
                end
            end
        end
    end

    // degrees: product magnitude, restoring division one bit per cycle
    logic [40:0] r_prod, r_quo;
    logic [24:0] r_rem;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [31:0] w_mag;
    logic [25:0] w_trial;
    assign w_mag = r_total[w_m][31] ? 32'(-r_total[w_m]) : r_total[w_m];
    assign w_trial = {r_rem, r_prod[40]} - {2'd0, r_cpt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mult) begin
            r_prod <= 41'(w_mag) * 41'd360;
            r_neg <= r_total[w_m][31];
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 6'(DivSteps - 1);
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[39:0], 1'b0};
            if (!w_trial[25]) begin
                r_rem <= w_trial[24:0];
                r_quo <= {r_quo[39:0], 1'b1};
            end else begin
                r_rem <= {r_rem[23:0], r_prod[40]};
                r_quo <= {r_quo[39:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end
    // one extra step: 41 quotient bits, then a last idle step that only raises done
    assign o_status.div_done = (r_cnt == 6'd0);

    logic signed [31:0] w_deg;
    always_comb begin
        if (r_cpt == '0) w_deg = '0;
        else if (!r_neg) w_deg = (r_quo > 41'h7FFFFFFF) ? 32'h7FFFFFFF : r_quo[31:0];
        else w_deg = (r_quo > 41'h80000000) ? 32'h80000000 : 32'(-r_quo[31:0]);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_slot <= r_slot;
            o_total_count <= r_oob ? '0 : r_total[w_m];
            o_angle_degrees <= r_oob ? '0 : w_deg;
            o_step_count <= r_oob ? '0 : r_lstep[w_m];
            o_lock_count <= r_oob ? '0 : r_held[w_m];
            o_speed_now <= r_oob ? '0 : r_speed[w_m];
            o_current_now <= r_oob ? '0 : r_cur[w_m];
            o_temperature_now <= r_oob ? '0 : r_temp[w_m];
            o_drive_enabled <= !r_oob && r_enable[w_m] && !r_fault[w_m];
            o_stall_alarm <= !r_oob && r_alarm[w_m];
        end
    end
endmodule

// ----- src/motor_feedback_tracker.sv -----
// A request passes through update, multiply, the divide steps and out; out loads the result register.
// A new request is taken only once the current one is done, bit-serial degree division included.
// The input is taken only while idle; the result register holds until taken.
// Reset (synchronous, active low) clears all motor state and loads register defaults.
// Each motor starts with its zero-on-first-frame flag set.
`include "motor_feedback_tracker_macros.svh"
module motor_feedback_tracker
    import mft_pkg::*;
#(
    parameter int unsigned MOTORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [2:0]         i_motor_index,
    input  logic [12:0]        i_angle_raw,
    input  logic signed [15:0] i_speed_raw,
    input  logic signed [15:0] i_current_raw,
    input  logic [7:0]         i_temperature_raw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_slot,
    output logic signed [31:0] o_total_count,
    output logic signed [31:0] o_angle_degrees,
    output logic signed [13:0] o_step_count,
    output logic signed [31:0] o_lock_count,
    output logic signed [15:0] o_speed_now,
    output logic signed [15:0] o_current_now,
    output logic [7:0]         o_temperature_now,
    output logic               o_drive_enabled,
    output logic               o_stall_alarm
);
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    mft_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    mft_dp #(.MOTORS(MOTORS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_operation, .i_motor_index, .i_angle_raw, .i_speed_raw,
        .i_current_raw, .i_temperature_raw,
        .o_slot, .o_total_count, .o_angle_degrees, .o_step_count, .o_lock_count,
        .o_speed_now, .o_current_now, .o_temperature_now, .o_drive_enabled,
        .o_stall_alarm
    );

    // an accepted request is followed by a busy input
    `MFT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a finish command is followed by a valid result
    `MFT_ASSERT_NEXT(a_result_from_finish, i_clk, i_rst_n, w_cmd.finish, o_valid)
    // loading a request never overlaps a divide step
    `MFT_ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, w_cmd.load, !w_cmd.div_step)
endmodule
